// ===== rtl/ps2dec_pkg.sv =====
// ---------------------------------------------------------------------------
// ps2dec_pkg
// Types, scancode constants and key maps shared by the set 1 decoder.
// ---------------------------------------------------------------------------
`default_nettype none

package ps2dec_pkg;

   localparam int QUEUE_DEPTH_DEF = 128;
   localparam int OPQ_DEPTH       = 2;
   localparam int LEVEL_W         = 7;
   localparam logic [LEVEL_W-1:0] LEVEL_MAX = 7'd127;

   localparam logic OP_SCAN = 1'b0;
   localparam logic OP_POP  = 1'b1;

   localparam logic [7:0] SC_PREFIX = 8'hE0;
   localparam logic [6:0] SC_ESC    = 7'h01;
   localparam logic [6:0] SC_CTRL   = 7'h1D;
   localparam logic [6:0] SC_LSHIFT = 7'h2A;
   localparam logic [6:0] SC_RSHIFT = 7'h36;
   localparam logic [6:0] SC_ALT    = 7'h38;
   localparam logic [6:0] SC_CAPS   = 7'h3A;
   localparam logic [6:0] SC_F1     = 7'h3B;
   localparam logic [6:0] SC_F10    = 7'h44;
   localparam logic [6:0] SC_F11    = 7'h57;
   localparam logic [6:0] SC_F12    = 7'h58;

   localparam logic [7:0] KC_NONE  = 8'h00;
   localparam logic [7:0] KC_ESC   = 8'h80;
   localparam logic [7:0] KC_F1    = 8'h81;
   localparam logic [7:0] KC_F11   = 8'h8B;
   localparam logic [7:0] KC_F12   = 8'h8C;
   localparam logic [7:0] KC_ALT_A = 8'hA0;

   localparam logic [6:0] TABLE_LEN = 7'h54;

   localparam logic [7:0] PLAIN_MAP [84] = '{
      8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
      8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09,
      8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
      8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00, 8'h61, 8'h73,
      8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
      8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,
      8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A,
      8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h37,
      8'h38, 8'h39, 8'h2D, 8'h34, 8'h35, 8'h36, 8'h2B, 8'h31,
      8'h32, 8'h33, 8'h30, 8'h2E
   };

   localparam logic [7:0] SHIFTED_MAP [84] = '{
      8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
      8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09,
      8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
      8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00, 8'h41, 8'h53,
      8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
      8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56,
      8'h42, 8'h4E, 8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A,
      8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h37,
      8'h38, 8'h39, 8'h2D, 8'h34, 8'h35, 8'h36, 8'h2B, 8'h31,
      8'h32, 8'h33, 8'h30, 8'h2E
   };

   typedef struct packed {
      logic       is_pop;
      logic       push_en;
      logic [7:0] push_code;
      logic       shift;
      logic       ctrl;
      logic       alt;
      logic       caps;
   } op_type;

   function automatic logic [7:0] key_map(input logic [6:0] code, input logic shifted);
      logic [7:0] val;
      val = KC_NONE;
      if (code < TABLE_LEN) begin
         val = shifted ? SHIFTED_MAP[code] : PLAIN_MAP[code];
      end
      return val;
   endfunction

   function automatic logic [7:0] nav_code(input logic [6:0] code);
      logic [7:0] val;
      unique case (code)
         7'h48:   val = 8'h8D;
         7'h50:   val = 8'h8E;
         7'h4B:   val = 8'h8F;
         7'h4D:   val = 8'h90;
         7'h47:   val = 8'h91;
         7'h4F:   val = 8'h92;
         7'h49:   val = 8'h93;
         7'h51:   val = 8'h94;
         7'h52:   val = 8'h95;
         7'h53:   val = 8'h96;
         default: val = KC_NONE;
      endcase
      return val;
   endfunction

   function automatic logic is_lower(input logic [7:0] v);
      return (v >= 8'h61) && (v <= 8'h7A);
   endfunction

   function automatic logic is_upper(input logic [7:0] v);
      return (v >= 8'h41) && (v <= 8'h5A);
   endfunction

endpackage

`default_nettype wire

// ===== rtl/ps2dec_ifs.sv =====
// ---------------------------------------------------------------------------
// ps2dec interfaces
// Request and response channels with valid/ready handshake.
// ---------------------------------------------------------------------------
`default_nettype none

interface ps2dec_req_if;
   logic       valid;
   logic       ready;
   logic       opcode;
   logic [7:0] scancode;

   modport source (output valid, output opcode, output scancode, input ready);
   modport sink   (input valid, input opcode, input scancode, output ready);
endinterface

interface ps2dec_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] key_code;
   logic       key_valid;
   logic [6:0] queue_level;
   logic       shift_held;
   logic       ctrl_held;
   logic       alt_held;
   logic       caps_on;
   logic       dropped;

   modport source (output valid, output key_code, output key_valid, output queue_level,
                   output shift_held, output ctrl_held, output alt_held, output caps_on,
                   output dropped, input ready);
   modport sink   (input valid, input key_code, input key_valid, input queue_level,
                   input shift_held, input ctrl_held, input alt_held, input caps_on,
                   input dropped, output ready);
endinterface

`default_nettype wire

// ===== rtl/ps2_set1_scancode_decoder.sv =====
// ---------------------------------------------------------------------------
// ps2_set1_scancode_decoder
// PS/2 set 1 scancode decoder with a queue of US-QWERTY key codes.
// ---------------------------------------------------------------------------
// Usage:
//   req_chan carries one request per handshake: opcode 0 feeds a raw set 1
//   scancode byte, opcode 1 pops one key code from the queue.
//   rsp_chan returns one response per request, in order: the popped code
//   (0 when none), queue level, modifier state and a drop flag.
//   An accepted request is written into the op queue; the back end takes
//   it from there and registers the response that rsp_chan then shows.
//   Throughput: one request per cycle while rsp_chan is ready. The key queue
//   is one memory; each op does at most one write or one registered read.
//   The queue holds QUEUE_DEPTH-1 codes; a push to a full queue is dropped.
//   Reset clears the modifiers, the prefix flag and the queue pointers; the
//   queue memory itself is not cleared and needs no clearing pass.
//   When rsp_chan stalls, the response holds and a two-entry op queue keeps
//   taking requests until it fills, then req_chan.ready drops.
// ---------------------------------------------------------------------------
`default_nettype none

module ps2_set1_scancode_decoder #(
   parameter int QUEUE_DEPTH = ps2dec_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic     clock,
   input  wire logic     reset,
   ps2dec_req_if.sink    req_chan,
   ps2dec_rsp_if.source  rsp_chan
);
   import ps2dec_pkg::*;

   logic   front_valid, front_ready;
   op_type front_op;
   logic   back_valid, back_ready;
   op_type back_op;

   ps2dec_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .op_valid (front_valid),
      .op_data  (front_op),
      .op_ready (front_ready)
   );

   ps2dec_opq u_opq (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_data   (front_op),
      .in_ready  (front_ready),
      .out_valid (back_valid),
      .out_data  (back_op),
      .out_ready (back_ready)
   );

   ps2dec_back #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .op_valid (back_valid),
      .op_data  (back_op),
      .op_ready (back_ready),
      .rsp_chan (rsp_chan)
   );

endmodule

`default_nettype wire

// ===== rtl/ps2dec_front.sv =====
// ---------------------------------------------------------------------------
// ps2dec_front
// Classify each request, track prefix and modifier state, build the op.
// ---------------------------------------------------------------------------
`default_nettype none

module ps2dec_front (
   input  wire logic             clock,
   input  wire logic             reset,
   ps2dec_req_if.sink            req_chan,
   output      logic             op_valid,
   output      ps2dec_pkg::op_type op_data,
   input  wire logic             op_ready
);
   import ps2dec_pkg::*;

   logic       shift_ff, ctrl_ff, alt_ff, caps_ff, ext_ff;
   logic       shift_in, ctrl_in, alt_in, caps_in, ext_in;
   logic       push_en;
   logic [7:0] push_code;
   logic [7:0] plain_val;
   logic [7:0] tab_val;
   logic [6:0] code;
   logic       rel;
   logic       take;

   assign code      = req_chan.scancode[6:0];
   assign rel       = req_chan.scancode[7];
   assign plain_val = key_map(code, 1'b0);
   assign tab_val   = key_map(code, shift_ff);
   assign take      = req_chan.valid && op_ready;

   always_comb begin
      shift_in  = shift_ff;
      ctrl_in   = ctrl_ff;
      alt_in    = alt_ff;
      caps_in   = caps_ff;
      ext_in    = ext_ff;
      push_en   = 1'b0;
      push_code = KC_NONE;
      if (req_chan.opcode == OP_POP) begin
         ext_in = ext_ff;
      end else if (req_chan.scancode == SC_PREFIX) begin
         ext_in = 1'b1;
      end else if (ext_ff) begin
         ext_in = 1'b0;
         priority if (code == SC_ALT) begin
            alt_in = !rel;
         end else if (code == SC_CTRL) begin
            ctrl_in = !rel;
         end else if (!rel) begin
            push_code = nav_code(code);
            push_en   = (push_code != KC_NONE);
         end else begin
            push_en = 1'b0;
         end
      end else begin
         priority if (code == SC_LSHIFT || code == SC_RSHIFT) begin
            shift_in = !rel;
         end else if (code == SC_CTRL) begin
            ctrl_in = !rel;
         end else if (code == SC_ALT) begin
            alt_in = !rel;
         end else if (code == SC_CAPS) begin
            if (!rel) begin
               caps_in = !caps_ff;
            end
         end else if (rel) begin
            push_en = 1'b0;
         end else if (code == SC_ESC) begin
            push_en   = 1'b1;
            push_code = KC_ESC;
         end else if (code >= SC_F1 && code <= SC_F10) begin
            push_en   = 1'b1;
            push_code = KC_F1 + {1'b0, code - SC_F1};
         end else if (code == SC_F11) begin
            push_en   = 1'b1;
            push_code = KC_F11;
         end else if (code == SC_F12) begin
            push_en   = 1'b1;
            push_code = KC_F12;
         end else if (code >= TABLE_LEN) begin
            push_en = 1'b0;
         end else if (alt_ff) begin
            if (is_lower(plain_val)) begin
               push_en   = 1'b1;
               push_code = KC_ALT_A + (plain_val - 8'h61);
            end
         end else begin
            push_code = tab_val;
            if (caps_ff && is_lower(tab_val)) begin
               push_code = tab_val - 8'd32;
            end else if (caps_ff && is_upper(tab_val)) begin
               push_code = tab_val + 8'd32;
            end
            push_en = (push_code != KC_NONE);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff <= 1'b0;
         ctrl_ff  <= 1'b0;
         alt_ff   <= 1'b0;
         caps_ff  <= 1'b0;
         ext_ff   <= 1'b0;
      end else if (take) begin
         shift_ff <= shift_in;
         ctrl_ff  <= ctrl_in;
         alt_ff   <= alt_in;
         caps_ff  <= caps_in;
         ext_ff   <= ext_in;
      end
   end

   assign req_chan.ready    = op_ready;
   assign op_valid          = req_chan.valid;
   assign op_data.is_pop    = (req_chan.opcode == OP_POP);
   assign op_data.push_en   = push_en;
   assign op_data.push_code = push_code;
   assign op_data.shift     = shift_in;
   assign op_data.ctrl      = ctrl_in;
   assign op_data.alt       = alt_in;
   assign op_data.caps      = caps_in;

endmodule

`default_nettype wire

// ===== rtl/ps2dec_opq.sv =====
// ---------------------------------------------------------------------------
// ps2dec_opq
// Short op queue between the classify front and the key-queue back.
// ---------------------------------------------------------------------------
`default_nettype none

module ps2dec_opq (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   input  wire ps2dec_pkg::op_type in_data,
   output      logic               in_ready,
   output      logic               out_valid,
   output      ps2dec_pkg::op_type out_data,
   input  wire logic               out_ready
);
   import ps2dec_pkg::*;

   localparam int IDX_W = $clog2(OPQ_DEPTH);
   localparam int CNT_W = $clog2(OPQ_DEPTH + 1);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(OPQ_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(OPQ_DEPTH);

   op_type           entry_ff [OPQ_DEPTH];
   logic [IDX_W-1:0] wr_idx_ff, wr_idx_in;
   logic [IDX_W-1:0] rd_idx_ff, rd_idx_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             push, pop;

   assign in_ready  = (cnt_ff != CNT_FULL);
   assign out_valid = (cnt_ff != '0);
   assign out_data  = entry_ff[rd_idx_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_idx_in = wr_idx_ff;
      rd_idx_in = rd_idx_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_idx_in = (wr_idx_ff == IDX_LAST) ? '0 : wr_idx_ff + 1'b1;
      end
      if (pop) begin
         rd_idx_in = (rd_idx_ff == IDX_LAST) ? '0 : rd_idx_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_idx_ff <= '0;
         rd_idx_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_idx_ff <= wr_idx_in;
         rd_idx_ff <= rd_idx_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_idx_ff] <= in_data;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/ps2dec_back.sv =====
// ---------------------------------------------------------------------------
// ps2dec_back
// Execute push and pop ops on the key-code queue, register the response.
// ---------------------------------------------------------------------------
`default_nettype none

module ps2dec_back #(
   parameter int QUEUE_DEPTH = ps2dec_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               op_valid,
   input  wire ps2dec_pkg::op_type op_data,
   output      logic               op_ready,
   ps2dec_rsp_if.source            rsp_chan
);
   import ps2dec_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CW    = (PTR_W > LEVEL_W) ? PTR_W : LEVEL_W;
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

   logic [7:0]         mem [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0]   cnt_ff, cnt_in;
   logic [CW-1:0]      cnt_ext;
   logic [7:0]         rdata_ff;
   logic               out_valid_ff;
   logic               key_valid_ff, key_valid_in;
   logic               dropped_ff, dropped_in;
   logic [LEVEL_W-1:0] level_ff, level_in;
   logic               shift_ff, ctrl_ff, alt_ff, caps_ff;
   logic               take, do_read, do_write;

   assign op_ready = !out_valid_ff || rsp_chan.ready;
   assign take     = op_valid && op_ready;

   always_comb begin
      wr_ptr_in    = wr_ptr_ff;
      rd_ptr_in    = rd_ptr_ff;
      cnt_in       = cnt_ff;
      do_read      = 1'b0;
      do_write     = 1'b0;
      key_valid_in = 1'b0;
      dropped_in   = 1'b0;
      if (take) begin
         if (op_data.is_pop) begin
            if (cnt_ff != '0) begin
               do_read      = 1'b1;
               key_valid_in = 1'b1;
               rd_ptr_in    = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
               cnt_in       = cnt_ff - 1'b1;
            end
         end else if (op_data.push_en) begin
            if (cnt_ff == PTR_LAST) begin
               dropped_in = 1'b1;
            end else begin
               do_write  = 1'b1;
               wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
               cnt_in    = cnt_ff + 1'b1;
            end
         end
      end
      cnt_ext  = CW'(cnt_in);
      level_in = (cnt_ext > CW'(LEVEL_MAX)) ? LEVEL_MAX : LEVEL_W'(cnt_ext);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
         if (op_ready) begin
            out_valid_ff <= op_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         key_valid_ff <= key_valid_in;
         dropped_ff   <= dropped_in;
         level_ff     <= level_in;
         shift_ff     <= op_data.shift;
         ctrl_ff      <= op_data.ctrl;
         alt_ff       <= op_data.alt;
         caps_ff      <= op_data.caps;
      end
   end

   always_ff @(posedge clock) begin
      if (do_write) begin
         mem[wr_ptr_ff] <= op_data.push_code;
      end
   end

   always_ff @(posedge clock) begin
      if (do_read) begin
         rdata_ff <= mem[rd_ptr_ff];
      end
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.key_code    = key_valid_ff ? rdata_ff : KC_NONE;
   assign rsp_chan.key_valid   = key_valid_ff;
   assign rsp_chan.queue_level = level_ff;
   assign rsp_chan.shift_held  = shift_ff;
   assign rsp_chan.ctrl_held   = ctrl_ff;
   assign rsp_chan.alt_held    = alt_ff;
   assign rsp_chan.caps_on     = caps_ff;
   assign rsp_chan.dropped     = dropped_ff;

endmodule

`default_nettype wire

// ===== rtl/ps2dec_checker.sv =====
// ---------------------------------------------------------------------------
// ps2dec_checker
// Port-level properties of the decoder, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module ps2dec_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] key_code,
   input wire logic       key_valid,
   input wire logic [6:0] queue_level,
   input wire logic       dropped
);

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_code_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (key_valid ? (key_code != 8'h00) : (key_code == 8'h00)))
      else $error("key code disagrees with key valid");

   a_drop_scan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && dropped |-> !key_valid && queue_level != 7'd0)
      else $error("drop flagged on a pop or with an empty queue");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(key_code) && $stable(queue_level))
      else $error("stalled response changed");

endmodule

bind ps2_set1_scancode_decoder ps2dec_checker u_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .key_code    (rsp_chan.key_code),
   .key_valid   (rsp_chan.key_valid),
   .queue_level (rsp_chan.queue_level),
   .dropped     (rsp_chan.dropped)
);

`default_nettype wire
